// ===== rtl/core/ctd_pkg.sv =====
// Shared types and byte codes for the charmap text decoder.
// Used by ctd_front, ctd_queue, ctd_back and the top level; no dependencies.
package ctd_pkg;

  localparam logic [7:0] BYTE_NUL   = 8'h00;
  localparam logic [7:0] BYTE_ESC   = 8'h7E;
  localparam logic [7:0] BYTE_TWO   = 8'h32;
  localparam logic [7:0] BYTE_SEVEN = 8'h37;
  localparam logic [7:0] BYTE_C     = 8'h63;
  localparam logic [7:0] BYTE_DROP0 = 8'h81;
  localparam logic [7:0] BYTE_DROP1 = 8'hBD;
  localparam logic [7:0] BYTE_DROP2 = 8'hBE;
  localparam logic [7:0] BYTE_SPACE = 8'h20;

  localparam logic [6:0] CHAR_DQUOTE = 7'h22;
  localparam logic [6:0] CHAR_APOS   = 7'h27;
  localparam logic [6:0] CHAR_COMMA  = 7'h2C;
  localparam logic [6:0] CHAR_TERM   = 7'h00;

  localparam logic [8:0] CAP_MAX       = 9'd256;
  localparam logic [8:0] CAP_RESET     = 9'd33;
  localparam logic [7:0] STEPS_RESET   = 8'd32;

  localparam logic REG_OUT_CAPACITY = 1'b0;
  localparam logic REG_MAX_STEPS    = 1'b1;

  typedef enum logic [3:0] {
    PH_NORMAL  = 4'b0001,
    PH_HELD7E  = 4'b0010,
    PH_HELD32  = 4'b0100,
    PH_DISCARD = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [6:0] ch;
    logic       last;
  } result_t;

  // One queue entry: the results caused by one input beat (one or two).
  typedef struct packed {
    logic    two;
    result_t first;
    result_t second;
  } entry_t;

endpackage

// ===== rtl/core/ctd_front.sv =====
// Front end: accepts source bytes, runs the lookahead decoder and pushes
// the results of each beat into the queue. Holds the config registers.
// Depends on ctd_pkg.
module ctd_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_valid,
  input  logic            cfg_index,
  input  logic [8:0]      cfg_data,
  input  logic            s_tvalid,
  output logic            s_tready,
  input  logic [7:0]      s_tdata,
  input  logic            q_full,
  output logic            q_push,
  output ctd_pkg::entry_t q_data
);
  import ctd_pkg::*;

  typedef struct packed {
    phase_t     phase;
    logic [7:0] chars;
    logic [7:0] steps;
    logic       emit;
    result_t    res;
  } lead_t;

  logic [8:0] out_capacity;
  logic [7:0] max_steps;
  phase_t     phase;
  logic [7:0] chars;
  logic [7:0] steps;
  logic [8:0] cap;
  logic       accept;
  lead_t      cur;
  lead_t      r1;
  lead_t      r2;
  lead_t      fin;
  logic       emit_a;
  logic       emit_b;
  result_t    res_a;
  result_t    res_b;

  // Decision on one leading byte.
  function automatic lead_t lead_byte(input lead_t st, input logic [7:0] b,
                                      input logic [8:0] cap_in,
                                      input logic [7:0] maxs);
    lead_t r;
    logic  room;
    r      = st;
    r.emit = 1'b0;
    r.res  = '0;
    room   = (({1'b0, st.chars} + 9'd1) < cap_in) && (st.steps < maxs);
    if (st.phase == PH_DISCARD) begin
      if (b == BYTE_NUL) begin
        r.phase = PH_NORMAL;
        r.chars = '0;
        r.steps = '0;
      end
    end else begin
      r.phase = PH_NORMAL;
      if (b == BYTE_NUL) begin
        r.chars    = '0;
        r.steps    = '0;
        r.emit     = 1'b1;
        r.res.ch   = CHAR_TERM;
        r.res.last = 1'b1;
      end else if (!room) begin
        r.phase    = PH_DISCARD;
        r.emit     = 1'b1;
        r.res.ch   = CHAR_TERM;
        r.res.last = 1'b1;
      end else begin
        r.steps = st.steps + 8'd1;
        if (b == BYTE_ESC) begin
          r.phase = PH_HELD7E;
        end else if (b == BYTE_DROP0 || b == BYTE_DROP1 || b == BYTE_DROP2) begin
          r.emit = 1'b0;
        end else if (b >= BYTE_SPACE && b <= BYTE_ESC) begin
          r.chars    = st.chars + 8'd1;
          r.emit     = 1'b1;
          r.res.ch   = b[6:0];
          r.res.last = 1'b0;
        end
      end
    end
    return r;
  endfunction

  assign cap      = (out_capacity > CAP_MAX) ? CAP_MAX : out_capacity;
  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    cur       = '0;
    cur.phase = PH_NORMAL;
    cur.chars = chars;
    cur.steps = steps;
    r1        = cur;
    r2        = cur;
    fin       = cur;
    emit_a    = 1'b0;
    emit_b    = 1'b0;
    res_a     = '0;
    res_b     = '0;
    unique case (phase)
      PH_HELD7E: begin
        if (s_tdata == BYTE_TWO) begin
          fin.phase = PH_HELD32;
        end else begin
          r1     = lead_byte(cur, s_tdata, cap, max_steps);
          fin    = r1;
          emit_a = r1.emit;
          res_a  = r1.res;
        end
      end
      PH_HELD32: begin
        if (s_tdata == BYTE_TWO || s_tdata == BYTE_SEVEN || s_tdata == BYTE_C) begin
          fin.chars  = chars + 8'd1;
          emit_a     = 1'b1;
          res_a.last = 1'b0;
          res_a.ch   = (s_tdata == BYTE_TWO) ? CHAR_DQUOTE :
                       (s_tdata == BYTE_SEVEN) ? CHAR_APOS : CHAR_COMMA;
        end else begin
          // Drop the escape, decide the held 32 alone, then the new byte.
          r1     = lead_byte(cur, BYTE_TWO, cap, max_steps);
          r2     = lead_byte(r1, s_tdata, cap, max_steps);
          fin    = r2;
          emit_a = r1.emit;
          res_a  = r1.res;
          emit_b = r2.emit;
          res_b  = r2.res;
        end
      end
      PH_DISCARD: begin
        cur.phase = PH_DISCARD;
        r1        = lead_byte(cur, s_tdata, cap, max_steps);
        fin       = r1;
      end
      default: begin
        r1     = lead_byte(cur, s_tdata, cap, max_steps);
        fin    = r1;
        emit_a = r1.emit;
        res_a  = r1.res;
      end
    endcase
  end

  always_comb begin
    q_push = accept && (emit_a || emit_b);
    q_data = '0;
    if (emit_a && emit_b) begin
      q_data.two    = 1'b1;
      q_data.first  = res_a;
      q_data.second = res_b;
    end else if (emit_a) begin
      q_data.first = res_a;
    end else begin
      q_data.first = res_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_NORMAL;
      chars <= '0;
      steps <= '0;
    end else if (accept) begin
      phase <= fin.phase;
      chars <= fin.chars;
      steps <= fin.steps;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_capacity <= CAP_RESET;
      max_steps    <= STEPS_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_OUT_CAPACITY: out_capacity <= cfg_data;
        REG_MAX_STEPS:    max_steps    <= cfg_data[7:0];
        default:          max_steps    <= max_steps;
      endcase
    end
  end

endmodule

// ===== rtl/core/ctd_queue.sv =====
// Short register queue of result entries between front and back end.
// Depends on ctd_pkg.
module ctd_queue #(
  parameter int DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  ctd_pkg::entry_t push_data,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output ctd_pkg::entry_t head
);
  import ctd_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

  entry_t           slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full       = (count == FULL_CNT);
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// ===== rtl/core/ctd_back.sv =====
// Back end: splits queue entries into single result beats and drives the
// registered master stream. Depends on ctd_pkg.
module ctd_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            head_valid,
  input  ctd_pkg::entry_t head,
  output logic            pop,
  output logic            m_tvalid,
  input  logic            m_tready,
  output logic [7:0]      m_tdata,
  output logic            m_tlast
);
  import ctd_pkg::*;

  logic       sub;
  logic       load;
  result_t    pick;
  logic [6:0] out_ch;
  logic       out_last;

  assign load    = head_valid && (!m_tvalid || m_tready);
  assign pick    = sub ? head.second : head.first;
  assign pop     = load && (sub || !head.two);
  assign m_tdata = {1'b0, out_ch};
  assign m_tlast = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      sub      <= 1'b0;
    end else begin
      if (load) begin
        m_tvalid <= 1'b1;
        // Advance to the second result, or release the entry.
        sub      <= !sub && head.two;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_ch   <= pick.ch;
      out_last <= pick.last;
    end
  end

endmodule

// ===== rtl/core/charmap_text_decoder.sv =====
// Charmap text decoder: one source byte in per cycle while the entry queue is not full,
// one ASCII result out per cycle while m_tready is high. Each result passes the entry
// queue and the registered output stage. A beat that yields two results leaves as two
// output beats; the queue absorbs that, and input stalls only while the queue is full.
// Reset: sync, active high; counters cleared, out_capacity 33, max_steps 32, queue empty.
// Depends on ctd_pkg, ctd_front, ctd_queue, ctd_back.
module charmap_text_decoder #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_index,
  input  logic [8:0] cfg_data,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] source_byte
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [6:0] ascii_char, [7] zero
  output logic       m_tlast    // is_last
);
  import ctd_pkg::*;

  logic   q_full;
  logic   q_push;
  entry_t q_push_data;
  logic   q_pop;
  logic   q_head_valid;
  entry_t q_head;

  assign cfg_ready = 1'b1;

  ctd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_push_data)
  );

  ctd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_data  (q_push_data),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head       (q_head)
  );

  ctd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (q_head_valid),
    .head       (q_head),
    .pop        (q_pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast)
  );

endmodule

// ===== tb/charmap_text_decoder_tb.sv =====
// Self-checking bench for charmap_text_decoder: a directed table followed by random strings.
// Results are checked against a predictor kept in this file. Depends on ctd_pkg and the DUT.
`timescale 1ns / 100ps

module charmap_text_decoder_tb;
  import ctd_pkg::*;

  // One input beat. Rows with typed set carry their expected characters;
  // all other rows take theirs from the predictor.
  typedef struct packed {
    logic [7:0] data;
    logic       typed;
    logic [1:0] n;
    result_t    r0;
    result_t    r1;
  } beat_plan_t;

  typedef enum {RX_STEADY, RX_COIN, RX_THIRDS, RX_MOSTLY} rx_style_t;

  localparam result_t R_NONE   = '0;
  localparam result_t R_TERM   = '{CHAR_TERM, 1'b1};
  localparam result_t R_SPACE  = '{7'h20, 1'b0};
  localparam result_t R_DQUOTE = '{CHAR_DQUOTE, 1'b0};
  localparam result_t R_APOS   = '{CHAR_APOS, 1'b0};
  localparam result_t R_COMMA  = '{CHAR_COMMA, 1'b0};

  localparam beat_plan_t DIRECTED [25] = '{
    '{BYTE_NUL,   1'b1, 2'd1, R_TERM,   R_NONE},
    '{BYTE_SPACE, 1'b1, 2'd1, R_SPACE,  R_NONE},
    '{BYTE_ESC,   1'b1, 2'd0, R_NONE,   R_NONE},
    '{BYTE_TWO,   1'b1, 2'd0, R_NONE,   R_NONE},
    '{BYTE_TWO,   1'b1, 2'd1, R_DQUOTE, R_NONE},
    '{BYTE_ESC,   1'b1, 2'd0, R_NONE,   R_NONE},
    '{BYTE_TWO,   1'b1, 2'd0, R_NONE,   R_NONE},
    '{BYTE_SEVEN, 1'b1, 2'd1, R_APOS,   R_NONE},
    '{BYTE_ESC,   1'b1, 2'd0, R_NONE,   R_NONE},
    '{BYTE_TWO,   1'b1, 2'd0, R_NONE,   R_NONE},
    '{BYTE_C,     1'b1, 2'd1, R_COMMA,  R_NONE},
    // escape followed by a plain byte
    '{BYTE_ESC,   1'b1, 2'd0, R_NONE,   R_NONE},
    '{8'h41,      1'b0, 2'd0, R_NONE,   R_NONE},
    // escape and 32 followed by a byte that completes no sequence
    '{BYTE_ESC,   1'b1, 2'd0, R_NONE,   R_NONE},
    '{BYTE_TWO,   1'b1, 2'd0, R_NONE,   R_NONE},
    '{8'h58,      1'b0, 2'd0, R_NONE,   R_NONE},
    '{BYTE_DROP0, 1'b1, 2'd0, R_NONE,   R_NONE},
    '{BYTE_DROP1, 1'b1, 2'd0, R_NONE,   R_NONE},
    '{BYTE_DROP2, 1'b1, 2'd0, R_NONE,   R_NONE},
    '{8'hFF,      1'b1, 2'd0, R_NONE,   R_NONE},
    '{8'h7F,      1'b1, 2'd0, R_NONE,   R_NONE},
    '{8'h1F,      1'b1, 2'd0, R_NONE,   R_NONE},
    // half sequence cut by the end of the string
    '{BYTE_ESC,   1'b1, 2'd0, R_NONE,   R_NONE},
    '{BYTE_TWO,   1'b1, 2'd0, R_NONE,   R_NONE},
    '{BYTE_NUL,   1'b0, 2'd0, R_NONE,   R_NONE}
  };

  localparam logic [8:0] PHASE_CAP   [6] = '{9'd1, 9'd256, 9'd2, 9'd0, 9'd511, 9'd12};
  localparam logic [7:0] PHASE_STEPS [6] = '{8'd255, 8'd255, 8'd1, 8'd0, 8'd200, 8'd9};

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic       cfg_index = REG_OUT_CAPACITY;
  logic [8:0] cfg_data = '0;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = '0;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic       m_tlast;

  // predictor state and its copy of the registers
  phase_t     dec_phase = PH_NORMAL;
  logic [7:0] dec_chars = '0;
  logic [7:0] dec_steps = '0;
  logic [8:0] cap_reg   = CAP_RESET;
  logic [7:0] steps_reg = STEPS_RESET;

  result_t    decoded_now [$];
  result_t    chars_due [$];
  beat_plan_t beats_in_flight [$];

  int mismatches = 0;
  int sent_items = 0;
  int burst_left = 0;
  bit hold_req = 1'b0;

  always #5 clk = ~clk;

  charmap_text_decoder u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

  function automatic void emit_char(input logic [6:0] ch, input logic last);
    result_t r;
    r.ch = ch;
    r.last = last;
    decoded_now.push_back(r);
  endfunction

  // Decision on one leading byte.
  function automatic void decode_lead(input logic [7:0] b);
    int cap_eff;
    cap_eff = (cap_reg > CAP_MAX) ? int'(CAP_MAX) : int'(cap_reg);
    if (dec_phase == PH_DISCARD) begin
      if (b == BYTE_NUL) begin
        dec_phase = PH_NORMAL;
        dec_chars = '0;
        dec_steps = '0;
      end
      return;
    end
    dec_phase = PH_NORMAL;
    if (b == BYTE_NUL) begin
      dec_chars = '0;
      dec_steps = '0;
      emit_char(CHAR_TERM, 1'b1);
      return;
    end
    if (!((int'(dec_chars) + 1 < cap_eff) && (dec_steps < steps_reg))) begin
      dec_phase = PH_DISCARD;
      emit_char(CHAR_TERM, 1'b1);
      return;
    end
    dec_steps = dec_steps + 8'd1;
    if (b == BYTE_ESC) begin
      dec_phase = PH_HELD7E;
    end else if (b == BYTE_DROP0 || b == BYTE_DROP1 || b == BYTE_DROP2) begin
      // dropped, the step still counts
    end else if (b >= BYTE_SPACE && b <= BYTE_ESC) begin
      dec_chars = dec_chars + 8'd1;
      emit_char(b[6:0], 1'b0);
    end
  endfunction

  function automatic void decode_byte(input logic [7:0] b);
    logic [6:0] ch;
    ch = CHAR_TERM;
    case (dec_phase)
      PH_HELD7E: begin
        dec_phase = PH_NORMAL;
        if (b == BYTE_TWO) dec_phase = PH_HELD32;
        else decode_lead(b);
      end
      PH_HELD32: begin
        dec_phase = PH_NORMAL;
        if (b == BYTE_TWO) ch = CHAR_DQUOTE;
        else if (b == BYTE_SEVEN) ch = CHAR_APOS;
        else if (b == BYTE_C) ch = CHAR_COMMA;
        if (ch != CHAR_TERM) begin
          dec_chars = dec_chars + 8'd1;
          emit_char(ch, 1'b0);
        end else begin
          // the held 32 is decided on its own, then the new byte
          decode_lead(BYTE_TWO);
          decode_lead(b);
        end
      end
      default: decode_lead(b);
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    mismatches++;
  endtask

  // Input side: predict on every accepted beat. Output side: check against the oldest char due.
  always @(posedge clk) begin : beat_monitor
    beat_plan_t p;
    result_t want;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        decoded_now.delete();
        decode_byte(s_tdata);
        if (beats_in_flight.size() == 0) begin
          report_mismatch($sformatf("input beat %02h accepted but none offered", s_tdata));
        end else begin
          p = beats_in_flight.pop_front();
          if (p.typed) begin
            if (p.n > 0) chars_due.push_back(p.r0);
            if (p.n > 1) chars_due.push_back(p.r1);
          end else begin
            foreach (decoded_now[i]) chars_due.push_back(decoded_now[i]);
          end
        end
      end
      if (m_tvalid && m_tready) begin
        if (chars_due.size() == 0) begin
          report_mismatch($sformatf("unexpected result data %02h last %0b", m_tdata, m_tlast));
        end else begin
          want = chars_due.pop_front();
          if (m_tdata != {1'b0, want.ch})
            report_mismatch($sformatf("ascii_char got %02h exp %02h", m_tdata, want.ch));
          if (m_tlast != want.last)
            report_mismatch($sformatf("is_last got %0b exp %0b", m_tlast, want.last));
        end
      end
    end
  end

  // Receiver: switches between random ready styles; a hold request stalls it, holding m_tready low.
  always @(posedge clk) begin : rx_pattern
    static int rx_hold = 0;
    static int rx_count = 0;
    static rx_style_t rx_style = RX_STEADY;
    if (hold_req) begin
      rx_hold = 60;
      hold_req = 1'b0;
    end
    if (rx_count == 0) begin
      rx_style = rx_style_t'($urandom_range(0, 3));
      rx_count = $urandom_range(8, 64);
    end
    rx_count--;
    if (rx_hold > 0) begin
      rx_hold--;
      m_tready <= 1'b0;
    end else begin
      case (rx_style)
        RX_STEADY: m_tready <= 1'b1;
        RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
        RX_THIRDS: m_tready <= (rx_count % 3 == 0);
        default:   m_tready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  task automatic send_byte(input beat_plan_t p);
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) begin
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    beats_in_flight.push_back(p);
    s_tvalid <= 1'b1;
    s_tdata  <= p.data;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    burst_left--;
    sent_items++;
  endtask

  task automatic send_loose(input logic [7:0] b);
    beat_plan_t p;
    p = '0;
    p.data = b;
    send_byte(p);
  endtask

  // Hold the sender until every beat is in and every char is out.
  task automatic drain();
    s_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (beats_in_flight.size() != 0 || chars_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [8:0] value);
    drain();
    // a beat with no result may still be in the pipe
    repeat (8) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_OUT_CAPACITY) cap_reg = value;
    else steps_reg = value[7:0];
  endtask

  // Mostly well-formed text with escapes, plus broken escapes, drop codes and noise.
  task automatic send_string(input int max_len);
    int len;
    int n;
    int kind;
    len = $urandom_range(0, max_len);
    n = 0;
    while (n < len) begin
      kind = $urandom_range(0, 99);
      if (kind < 45) begin
        send_loose(8'($urandom_range(32'h20, 32'h7D)));
        n++;
      end else if (kind < 63) begin
        send_loose(BYTE_ESC);
        send_loose(BYTE_TWO);
        case ($urandom_range(0, 2))
          0:       send_loose(BYTE_TWO);
          1:       send_loose(BYTE_SEVEN);
          default: send_loose(BYTE_C);
        endcase
        n += 3;
      end else if (kind < 72) begin
        send_loose(BYTE_ESC);
        if ($urandom_range(0, 1) != 0) send_loose(BYTE_TWO);
        send_loose(8'($urandom_range(1, 255)));
        n += 3;
      end else if (kind < 80) begin
        case ($urandom_range(0, 2))
          0:       send_loose(BYTE_DROP0);
          1:       send_loose(BYTE_DROP1);
          default: send_loose(BYTE_DROP2);
        endcase
        n++;
      end else if (kind < 90) begin
        send_loose(8'($urandom_range(0, 255)));
        n++;
      end else begin
        send_loose(BYTE_ESC);
        send_loose(BYTE_ESC);
        n += 2;
      end
    end
    if ($urandom_range(0, 9) != 0) send_loose(BYTE_NUL);
  endtask

  initial begin
    #2ms;
    $display("charmap_text_decoder regression: fail");
    $finish;
  end

  initial begin
    int phase_start;
    logic [8:0] cap_val;
    logic [8:0] steps_val;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed rows run on the reset values of both registers
    for (int i = 0; i < 25; i++) send_byte(DIRECTED[i]);

    for (int ph = 0; ph < 8; ph++) begin
      if (ph < 6) begin
        cap_val = PHASE_CAP[ph];
        steps_val = {1'b0, PHASE_STEPS[ph]};
      end else begin
        cap_val = 9'($urandom_range(1, 40));
        steps_val = 9'($urandom_range(1, 40));
      end
      // upper data bit is not part of max_steps
      steps_val[8] = 1'($urandom_range(0, 1));
      write_reg(REG_OUT_CAPACITY, cap_val);
      write_reg(REG_MAX_STEPS, steps_val);
      // long stall on the output while input keeps coming
      if (ph == 1) hold_req = 1'b1;
      phase_start = sent_items;
      send_string(20);
      drain();
      while (sent_items - phase_start < 30) send_string(20);
    end

    drain();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("charmap_text_decoder regression: pass");
    end else begin
      $display("charmap_text_decoder regression: fail");
    end
    $finish;
  end

endmodule
